[sv/dtti_pkg.sv]
// Package with the shared types and constants of the decimal text parser.
`timescale 1ns / 1ps

package dtti_pkg;

    // Parser position within one number.
    typedef enum logic [3:0] {
        PH_SIGN = 4'b0001,
        PH_PRE  = 4'b0010,
        PH_DIG  = 4'b0100,
        PH_KEY  = 4'b1000
    } t_phase;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_DIGIT  = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_TOO_SMALL = 2'd3
    } t_status;

    // What kind of result a character produces.
    typedef enum logic [1:0] {
        EM_NONE = 2'd0,
        EM_DIG  = 2'd1,
        EM_INF  = 2'd2,
        EM_ERR  = 2'd3
    } t_emit;

    // Configuration register indexes.
    localparam logic [0:0] REG_NARROW_MODE     = 1'd0;
    localparam logic [0:0] REG_ACCEPT_INFINITY = 1'd1;

    // Character codes.
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_I        = 8'h49;
    localparam logic [7:0] CH_N        = 8'h4E;
    localparam logic [7:0] CH_F        = 8'h46;
    localparam logic [7:0] CH_CASE_BIT = 8'h20;

    // Range limits.
    localparam logic [31:0] VALUE_MAX_32 = 32'h7FFF_FFFF;
    localparam logic [31:0] VALUE_MIN_32 = 32'h8000_0000;
    localparam logic [31:0] VALUE_MAX_16 = 32'h0000_7FFF;
    localparam logic [31:0] VALUE_MIN_16 = 32'hFFFF_8000;

    // Result word layout.
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CHAR_W   = 8;
    localparam int OUT_W    = 48;

endpackage

[sv/decimal_text_to_integer.sv]
// Top level of the streaming signed decimal text to integer parser.
`timescale 1ns / 1ps

// Channel  Direction  Payload
// s        in         tdata = ch[7:0]; tlast = last
// m        out        tdata = value[31:0], status[33:32], stop_char[41:34], zeros[47:42];
//                     tlast = ended_by_text_end
// cfg      in         index 0 narrow_mode, index 1 accept_infinity; data[0] = value
//
// One character is accepted per cycle unless a stalled result holds the character register.
// The character register feeds the parse logic (one multiply-by-ten add and range check),
// which loads the result register. Reset clears the parser state, the configuration and the
// valid flags of both registers.
// While a result waits, the character register holds and the input takes a character only while it is empty.
// Configuration writes are always taken; o_cfg_ready is tied high.

module decimal_text_to_integer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // ch[7:0]
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // value[31:0], status[33:32], stop_char[41:34]
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [0:0]  i_cfg_data
);

    // Configuration.
    logic r_narrow;
    logic r_accept_inf;

    // Character register.
    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_last;

    // Parser state.
    dtti_pkg::t_phase r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [31:0]      r_acc, n_acc;
    logic [1:0]       r_kw, n_kw;
    logic             r_swallow, n_swallow;

    // Result register.
    logic                    r_out_valid;
    logic [31:0]             r_out_value;
    dtti_pkg::t_status       r_out_status;
    logic [7:0]              r_out_stop;
    logic                    r_out_ended;

    logic                    fire;
    logic                    s_accept;
    logic                    is_digit;
    logic                    is_space;
    logic [3:0]              digit_val;
    logic [35:0]             acc_ext;
    logic [35:0]             acc_x10;
    logic [35:0]             nv_dig;
    logic                    ovf_dig;
    dtti_pkg::t_emit         kind;
    logic [7:0]              res_stop;
    logic                    res_ended;
    logic [31:0]             res_value;
    dtti_pkg::t_status       res_status;
    logic                    emit;

    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign is_digit  = r_in_ch inside {[dtti_pkg::CH_0 : dtti_pkg::CH_9]};
    assign is_space  = r_in_ch inside {dtti_pkg::CH_SPACE, [dtti_pkg::CH_TAB : dtti_pkg::CH_CR]};
    assign digit_val = r_in_ch[3:0];

    // acc * 10 -/+ digit in 36 bits; the number is in range when the top five bits agree.
    assign acc_ext = {{4{r_acc[31]}}, r_acc};
    assign acc_x10 = (acc_ext << 3) + (acc_ext << 1);
    assign nv_dig  = r_neg ? (acc_x10 - {32'd0, digit_val}) : (acc_x10 + {32'd0, digit_val});
    assign ovf_dig = (nv_dig[35:31] != 5'b00000) && (nv_dig[35:31] != 5'b11111);

    always_comb begin
        logic do_pre;
        do_pre    = 1'b0;
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_acc     = r_acc;
        n_kw      = r_kw;
        n_swallow = r_swallow;
        kind      = dtti_pkg::EM_NONE;
        res_stop  = r_in_ch;
        res_ended = 1'b0;

        case (r_phase)
            dtti_pkg::PH_DIG: begin
                if (is_digit) begin
                    if (!r_swallow) begin
                        if (ovf_dig) begin
                            n_swallow = 1'b1;
                        end else begin
                            n_acc = nv_dig[31:0];
                        end
                    end
                end else begin
                    kind = dtti_pkg::EM_DIG;
                end
            end
            dtti_pkg::PH_KEY: begin
                if (r_kw == 2'd1 &&
                        (r_in_ch | dtti_pkg::CH_CASE_BIT) ==
                        (dtti_pkg::CH_N | dtti_pkg::CH_CASE_BIT)) begin
                    n_kw = 2'd2;
                end else if (r_kw == 2'd2 &&
                        (r_in_ch | dtti_pkg::CH_CASE_BIT) ==
                        (dtti_pkg::CH_F | dtti_pkg::CH_CASE_BIT)) begin
                    kind = dtti_pkg::EM_INF;
                end else begin
                    kind = dtti_pkg::EM_ERR;
                end
            end
            dtti_pkg::PH_PRE: begin
                do_pre = 1'b1;
            end
            default: begin
                // Before the sign; unknown codes behave the same way.
                if (is_space) begin
                    n_phase = r_phase;
                end else if (r_in_ch == dtti_pkg::CH_PLUS || r_in_ch == dtti_pkg::CH_MINUS) begin
                    n_neg   = (r_in_ch == dtti_pkg::CH_MINUS);
                    n_phase = dtti_pkg::PH_PRE;
                end else begin
                    n_phase = dtti_pkg::PH_PRE;
                    do_pre  = 1'b1;
                end
            end
        endcase

        if (do_pre && !is_space) begin
            if (is_digit) begin
                // The first digit can never leave the 32-bit range.
                n_phase   = dtti_pkg::PH_DIG;
                n_swallow = 1'b0;
                n_acc     = r_neg ? (32'd0 - {28'd0, digit_val}) : {28'd0, digit_val};
            end else if (r_accept_inf &&
                    (r_in_ch | dtti_pkg::CH_CASE_BIT) ==
                    (dtti_pkg::CH_I | dtti_pkg::CH_CASE_BIT)) begin
                n_phase = dtti_pkg::PH_KEY;
                n_kw    = 2'd1;
            end else begin
                kind = dtti_pkg::EM_ERR;
            end
        end

        if (kind == dtti_pkg::EM_NONE && r_in_last) begin
            res_stop  = 8'd0;
            res_ended = 1'b1;
            kind      = (n_phase == dtti_pkg::PH_DIG) ? dtti_pkg::EM_DIG : dtti_pkg::EM_ERR;
        end

        res_value  = 32'd0;
        res_status = dtti_pkg::ST_OK;
        case (kind)
            dtti_pkg::EM_DIG: begin
                if (n_swallow) begin
                    res_status = n_neg ? dtti_pkg::ST_TOO_SMALL : dtti_pkg::ST_TOO_LARGE;
                end else if (r_narrow && !n_acc[31] && n_acc[30:15] != 16'h0000) begin
                    res_status = dtti_pkg::ST_TOO_LARGE;
                end else if (r_narrow && n_acc[31] && n_acc[30:15] != 16'hFFFF) begin
                    res_status = dtti_pkg::ST_TOO_SMALL;
                end else begin
                    res_value = n_acc;
                end
            end
            dtti_pkg::EM_INF: begin
                if (r_neg) begin
                    res_value = r_narrow ? dtti_pkg::VALUE_MIN_16 : dtti_pkg::VALUE_MIN_32;
                end else begin
                    res_value = r_narrow ? dtti_pkg::VALUE_MAX_16 : dtti_pkg::VALUE_MAX_32;
                end
            end
            dtti_pkg::EM_ERR: begin
                res_status = dtti_pkg::ST_NO_DIGIT;
            end
            default: begin
                res_status = dtti_pkg::ST_OK;
            end
        endcase

        emit = (kind != dtti_pkg::EM_NONE);

        // Any result or the end of the text starts a fresh number.
        if (emit) begin
            n_phase   = dtti_pkg::PH_SIGN;
            n_neg     = 1'b0;
            n_acc     = 32'd0;
            n_kw      = 2'd0;
            n_swallow = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow     <= 1'b0;
            r_accept_inf <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == dtti_pkg::REG_NARROW_MODE) begin
                r_narrow <= i_cfg_data[0];
            end else begin
                r_accept_inf <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_ch   <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= dtti_pkg::PH_SIGN;
            r_neg     <= 1'b0;
            r_acc     <= 32'd0;
            r_kw      <= 2'd0;
            r_swallow <= 1'b0;
        end else if (fire) begin
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_acc     <= n_acc;
            r_kw      <= n_kw;
            r_swallow <= n_swallow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_value  <= res_value;
            r_out_status <= res_status;
            r_out_stop   <= res_stop;
            r_out_ended  <= res_ended;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_stop, r_out_status, r_out_value};
    assign o_m_tlast  = r_out_ended;

endmodule

[sv/dtti_checker.sv]
// Port-level checker for the decimal text parser and its bind statement.
`timescale 1ns / 1ps

module dtti_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tlast
);

    logic [1:0] status;
    logic [7:0] stop_char;

    assign status    = o_m_tdata[33:32];
    assign stop_char = o_m_tdata[41:34];

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // Error results carry a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && status != dtti_pkg::ST_OK |-> o_m_tdata[31:0] == 32'd0)
        else $error("error result with nonzero value");

    // A result from the end of the text reports no stop character.
    a_end_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> stop_char == 8'd0)
        else $error("text end result with stop character");

    // A digit never ends a successfully parsed number.
    a_ok_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && status == dtti_pkg::ST_OK && !o_m_tlast |->
        (stop_char < dtti_pkg::CH_0 || stop_char > dtti_pkg::CH_9))
        else $error("digit reported as stop character");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind decimal_text_to_integer dtti_checker u_dtti_checker (.*);

[sim/tb_top.sv]
// Self-checking testbench for decimal_text_to_integer with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_CHARS  = 215;

    typedef struct {
        logic [31:0]       value;
        dtti_pkg::t_status status;
        logic [7:0]        stop;
        logic              ended;
    } t_parse_result;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char_item;

    // Tracks the parser state and holds the results still owed by the block.
    class int_parse_board;
        bit                narrow;
        bit                allow_inf;
        dtti_pkg::t_phase  phase;
        bit                neg;
        logic signed [31:0] acc;
        int unsigned       kw_seen;
        bit                swallow;
        t_parse_result     want_q[$];
        int                errors;
        int                results_seen;

        function new();
            narrow = 1'b0;
            allow_inf = 1'b0;
            errors = 0;
            results_seen = 0;
            clear_number();
        endfunction

        function void clear_number();
            phase = dtti_pkg::PH_SIGN;
            neg = 1'b0;
            acc = '0;
            kw_seen = 0;
            swallow = 1'b0;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void set_reg(logic [0:0] idx, logic [0:0] val);
            if (idx == dtti_pkg::REG_NARROW_MODE) begin
                narrow = val;
            end else if (idx == dtti_pkg::REG_ACCEPT_INFINITY) begin
                allow_inf = val;
            end
        endfunction

        function bit is_space(logic [7:0] c);
            return c == dtti_pkg::CH_SPACE || (c >= dtti_pkg::CH_TAB && c <= dtti_pkg::CH_CR);
        endfunction

        function bit is_letter(logic [7:0] c, logic [7:0] up);
            return c == up || c == (up | dtti_pkg::CH_CASE_BIT);
        endfunction

        function t_parse_result close_number(logic [31:0] v, dtti_pkg::t_status st,
                                             logic [7:0] stop, logic ended);
            t_parse_result r;
            r.value = (st == dtti_pkg::ST_OK) ? v : '0;
            r.status = st;
            r.stop = stop;
            r.ended = ended;
            clear_number();
            return r;
        endfunction

        function void add_digit(int d);
            longint nv;
            if (swallow) return;
            nv = longint'(acc) * 10;
            if (neg) nv -= d;
            else nv += d;
            if (nv > longint'($signed(dtti_pkg::VALUE_MAX_32)) ||
                nv < longint'($signed(dtti_pkg::VALUE_MIN_32))) begin
                swallow = 1'b1;
            end else begin
                acc = nv[31:0];
            end
        endfunction

        function t_parse_result finish_digits(logic [7:0] stop, logic ended);
            longint            v;
            dtti_pkg::t_status st;
            v = longint'(acc);
            st = dtti_pkg::ST_OK;
            if (swallow) st = neg ? dtti_pkg::ST_TOO_SMALL : dtti_pkg::ST_TOO_LARGE;
            else if (narrow && v > longint'($signed(dtti_pkg::VALUE_MAX_16)))
                st = dtti_pkg::ST_TOO_LARGE;
            else if (narrow && v < longint'($signed(dtti_pkg::VALUE_MIN_16)))
                st = dtti_pkg::ST_TOO_SMALL;
            return close_number(acc, st, stop, ended);
        endfunction

        function t_parse_result finish_inf(logic [7:0] stop);
            logic [31:0] v;
            if (neg) v = narrow ? dtti_pkg::VALUE_MIN_16 : dtti_pkg::VALUE_MIN_32;
            else v = narrow ? dtti_pkg::VALUE_MAX_16 : dtti_pkg::VALUE_MAX_32;
            return close_number(v, dtti_pkg::ST_OK, stop, 1'b0);
        endfunction

        function void predict_char(logic [7:0] c, logic lst);
            t_parse_result r;
            bit got;
            bit digit;
            bit done;
            got = 1'b0;
            done = 1'b0;
            digit = (c >= dtti_pkg::CH_0) && (c <= dtti_pkg::CH_9);
            case (phase)
                dtti_pkg::PH_DIG: begin
                    if (digit) begin
                        add_digit(c - dtti_pkg::CH_0);
                    end else begin
                        r = finish_digits(c, 1'b0);
                        got = 1'b1;
                    end
                end
                dtti_pkg::PH_KEY: begin
                    if (kw_seen == 1 && is_letter(c, dtti_pkg::CH_N)) begin
                        kw_seen = 2;
                    end else if (kw_seen == 2 && is_letter(c, dtti_pkg::CH_F)) begin
                        r = finish_inf(c);
                        got = 1'b1;
                    end else begin
                        r = close_number('0, dtti_pkg::ST_NO_DIGIT, c, 1'b0);
                        got = 1'b1;
                    end
                end
                default: begin
                    // Before the sign, whitespace and one sign are taken; anything else
                    // falls through to the rules that apply before the digits.
                    if (phase != dtti_pkg::PH_PRE) begin
                        if (is_space(c)) begin
                            done = 1'b1;
                        end else if (c == dtti_pkg::CH_PLUS || c == dtti_pkg::CH_MINUS) begin
                            neg = (c == dtti_pkg::CH_MINUS);
                            phase = dtti_pkg::PH_PRE;
                            done = 1'b1;
                        end else begin
                            phase = dtti_pkg::PH_PRE;
                        end
                    end
                    if (!done && !is_space(c)) begin
                        if (digit) begin
                            phase = dtti_pkg::PH_DIG;
                            acc = '0;
                            swallow = 1'b0;
                            add_digit(c - dtti_pkg::CH_0);
                        end else if (allow_inf && is_letter(c, dtti_pkg::CH_I)) begin
                            phase = dtti_pkg::PH_KEY;
                            kw_seen = 1;
                        end else begin
                            r = close_number('0, dtti_pkg::ST_NO_DIGIT, c, 1'b0);
                            got = 1'b1;
                        end
                    end
                end
            endcase
            if (got) begin
                if (lst) clear_number();
            end else if (lst) begin
                if (phase == dtti_pkg::PH_DIG) r = finish_digits(8'h00, 1'b1);
                else r = close_number('0, dtti_pkg::ST_NO_DIGIT, 8'h00, 1'b1);
                got = 1'b1;
            end
            if (got) want_q.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [47:0] data, logic lst);
            t_parse_result want;
            if (want_q.size() == 0) begin
                report($sformatf("result with nothing expected, tdata=%h tlast=%b", data, lst));
                return;
            end
            want = want_q.pop_front();
            results_seen++;
            if (data[31:0] !== want.value)
                report($sformatf("value %h, expected %h", data[31:0], want.value));
            if (data[33:32] !== want.status)
                report($sformatf("status %0d, expected %0d", data[33:32], want.status));
            if (data[41:34] !== want.stop)
                report($sformatf("stop char %h, expected %h", data[41:34], want.stop));
            if (data[47:42] !== '0)
                report($sformatf("padding bits %b are not zero", data[47:42]));
            if (lst !== want.ended)
                report($sformatf("text end flag %b, expected %b", lst, want.ended));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [0:0]  i_cfg_data = '0;

    int_parse_board board = new();
    t_char_item     text_q[$];
    bit             tx_idle_on = 1'b0;
    bit             rx_idle_on = 1'b0;
    bit             long_hold_req = 1'b0;
    int             chars_sent = 0;
    int             settings_used = 0;
    int             quiet_cycles = 0;

    decimal_text_to_integer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Inputs are noted before outputs are checked, so a result never races its character.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) board.set_reg(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && o_s_tready) board.predict_char(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) board.check_result(o_m_tdata, o_m_tlast);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_char(logic [7:0] c, logic lst);
        if (tx_idle_on && $urandom_range(0, 6) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= c;
        i_s_tlast <= lst;
        do @(posedge i_clk); while (!o_s_tready);
        chars_sent++;
    endtask

    task automatic send_text(string s, bit close);
        for (int i = 0; i < s.len(); i++) send_char(s[i], close && i == s.len() - 1);
    endtask

    // The first edge lets the monitor note the character just accepted.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(bit narrow, bit inf);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= dtti_pkg::REG_NARROW_MODE;
        i_cfg_data <= narrow;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= dtti_pkg::REG_ACCEPT_INFINITY;
        i_cfg_data <= inf;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic void push_char(logic [7:0] c, logic lst = 1'b0);
        text_q.push_back('{c, lst});
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endfunction

    function automatic logic [7:0] rand_space();
        return ($urandom_range(0, 2) == 0) ? dtti_pkg::CH_SPACE :
               8'($urandom_range(dtti_pkg::CH_TAB, dtti_pkg::CH_CR));
    endfunction

    function automatic logic [7:0] rand_non_digit();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c >= dtti_pkg::CH_0 && c <= dtti_pkg::CH_9);
        return c;
    endfunction

    function automatic void gen_number();
        longint unsigned mag;
        int pick;
        int n;
        repeat ($urandom_range(0, 2)) push_char(rand_space());
        pick = $urandom_range(0, 9);
        if (pick < 4) push_char($urandom_range(0, 1) ? dtti_pkg::CH_MINUS : dtti_pkg::CH_PLUS);
        if (pick == 0) push_char(rand_space());
        case ($urandom_range(0, 9))
            0, 1, 2, 3: push_str($sformatf("%0d", $urandom % (10 ** $urandom_range(1, 5))));
            4, 5, 6: begin
                // Values around both range limits, including the most negative one.
                case ($urandom_range(0, 4))
                    0: mag = 64'd32768;
                    1: mag = 64'd65536;
                    2: mag = 64'd1000000000;
                    3: mag = 64'd2147483648;
                    default: mag = 64'd2147483649;
                endcase
                mag = mag - $urandom_range(0, 2);
                push_str($sformatf("%0d", mag));
            end
            7: begin
                mag = $urandom;
                push_str($sformatf("%0d", mag));
            end
            8: begin
                n = $urandom_range(10, 14);
                repeat (n) push_char(8'(dtti_pkg::CH_0 + $urandom_range(0, 9)));
            end
            default: begin
                push_str("00");
                push_str($sformatf("%0d", $urandom_range(0, 999)));
            end
        endcase
        if ($urandom_range(0, 3) == 0) begin
            text_q[text_q.size() - 1].last = 1'b1;
        end else begin
            push_char(rand_non_digit(), $urandom_range(0, 7) == 0);
        end
    endfunction

    function automatic void gen_keyword();
        logic [7:0] letters[3];
        int n;
        letters = '{dtti_pkg::CH_I, dtti_pkg::CH_N, dtti_pkg::CH_F};
        if ($urandom_range(0, 2) == 0) push_char(rand_space());
        if ($urandom_range(0, 1) == 0)
            push_char($urandom_range(0, 1) ? dtti_pkg::CH_MINUS : dtti_pkg::CH_PLUS);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 3;
        for (int i = 0; i < n; i++)
            push_char(letters[i] | ($urandom_range(0, 1) ? dtti_pkg::CH_CASE_BIT : 8'h00));
        if (n < 3) begin
            if ($urandom_range(0, 1) == 0) text_q[text_q.size() - 1].last = 1'b1;
            else push_char(8'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 5) == 0) begin
            text_q[text_q.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void gen_token();
        int pick;
        text_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 70) gen_number();
        else if (pick < 82) gen_keyword();
        else repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)),
                                                     $urandom_range(0, 11) == 0);
    endfunction

    task automatic run_random(int count);
        int start;
        start = chars_sent;
        while (chars_sent - start < count) begin
            gen_token();
            foreach (text_q[i]) send_char(text_q[i].ch, text_q[i].last);
        end
    endtask

    initial begin
        bit narrow_set[4];
        bit inf_set[4];
        narrow_set = '{1'b0, 1'b1, 1'b1, 1'b0};
        inf_set = '{1'b1, 1'b0, 1'b1, 1'b0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        // Reset register values: whitespace, signs, a second sign, missing digits,
        // text end after digits and after whitespace only, and both byte extremes.
        send_text(" -7x", 1'b0);
        send_text("+ -", 1'b0);
        send_text("9", 1'b1);
        send_text(" ", 1'b1);
        send_text("q", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        wait_drained();

        // Narrow range with the keyword: saturation, a partial keyword at text end,
        // a broken keyword, and a value beyond the 16-bit range.
        apply_setting(1'b1, 1'b1);
        send_text("-InF", 1'b0);
        send_text("iN", 1'b1);
        send_text("ix", 1'b0);
        send_text("+40000 ", 1'b0);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            if (p == 3) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            apply_setting(narrow_set[p], inf_set[p]);
            if (p == 0) begin
                // Hold off the output long enough for the block to stall its input.
                long_hold_req = 1'b1;
                repeat (20) begin
                    send_char(8'($urandom_range(dtti_pkg::CH_0, dtti_pkg::CH_9)), 1'b0);
                    send_text(";", 1'b0);
                end
                run_random(PHASE_CHARS / 2);
                wait_drained();
                run_random(PHASE_CHARS / 2);
            end else begin
                run_random(PHASE_CHARS);
            end
            wait_drained();
        end

        $display("tb_top summary: %0d characters sent, %0d results checked, %0d register settings",
                 chars_sent, board.results_seen, settings_used);
        $display("tb_top summary: signs, whitespace, keyword, 16/32-bit limits and a long stall");
        if (board.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/dtti_pkg.sv
sv/decimal_text_to_integer.sv
sv/dtti_checker.sv
sim/tb_top.sv
